### sv/wpm_pkg.sv
// shared constants and types for the wildcard pattern matcher
package wpm_pkg;

  localparam int CH_W       = 8;
  localparam int POS_W      = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int WORD_CHARS = CFG_DATA_W / CH_W;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_W0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EXACT       = 3'd5;

  // special pattern characters
  localparam logic [CH_W-1:0] CH_ONE = 8'h3F;
  localparam logic [CH_W-1:0] CH_ANY = 8'h2A;
  localparam logic [CH_W-1:0] CH_NUL = 8'h00;

  typedef logic [POS_W-1:0] pos_t;

  typedef struct packed {
    pos_t pat_pos;
    pos_t star_pos;
    logic star_seen;
    logic skipping;
    logic failed;
    logic overrun;
  } match_st_t;

endpackage

### sv/wpm_cfg.sv
// pattern register bank with per-position end and wildcard flags
module wpm_cfg
  import wpm_pkg::*;
#(
  parameter int MAX_PATTERN = 32,
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1,
  localparam int SLOTS = 1 << IDX_W
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata,
  output logic [MAX_PATTERN*CH_W-1:0] pat_chars,
  output logic [SLOTS-1:0]            dead,
  output logic [SLOTS-1:0]            is_one,
  output logic [SLOTS-1:0]            is_any,
  output logic                        exact
);

  logic [MAX_PATTERN*CH_W-1:0] pat_r, pat_nxt;
  pos_t                        len_r, len_nxt;
  pos_t                        lim_nxt;
  logic                        exact_r, exact_nxt;
  logic [MAX_PATTERN-1:0]      zero_nxt;
  logic [MAX_PATTERN-1:0]      dead_r, dead_nxt;

  always_comb begin
    pat_nxt   = pat_r;
    len_nxt   = len_r;
    exact_nxt = exact_r;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (cfg_we && cfg_index == CFG_PATTERN_W0 + CFG_IDX_W'(i / WORD_CHARS)) begin
        pat_nxt[i*CH_W +: CH_W] = cfg_wdata[(i % WORD_CHARS)*CH_W +: CH_W];
      end
    end
    if (cfg_we && cfg_index == CFG_PATTERN_LEN) begin
      len_nxt = cfg_wdata[POS_W-1:0];
    end
    if (cfg_we && cfg_index == CFG_EXACT) begin
      exact_nxt = cfg_wdata[0];
    end
  end

  // a position is dead when past the saturated length or at/after the first nul
  always_comb begin
    lim_nxt = (len_nxt > POS_W'(MAX_PATTERN)) ? POS_W'(MAX_PATTERN) : len_nxt;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      zero_nxt[i] = (pat_nxt[i*CH_W +: CH_W] == CH_NUL);
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      dead_nxt[i] = (POS_W'(i) >= lim_nxt) ||
                    (|(zero_nxt & ({MAX_PATTERN{1'b1}} >> (MAX_PATTERN - 1 - i))));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r   <= '0;
      len_r   <= '0;
      exact_r <= 1'b1;
      dead_r  <= '1;
    end else begin
      pat_r   <= pat_nxt;
      len_r   <= len_nxt;
      exact_r <= exact_nxt;
      dead_r  <= dead_nxt;
    end
  end

  always_comb begin
    dead   = '1;
    is_one = '0;
    is_any = '0;
    dead[MAX_PATTERN-1:0] = dead_r;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      is_one[i] = (pat_r[i*CH_W +: CH_W] == CH_ONE);
      is_any[i] = (pat_r[i*CH_W +: CH_W] == CH_ANY);
    end
  end

  assign pat_chars = pat_r;
  assign exact     = exact_r;

endmodule

### sv/wildcard_pattern_matcher_top.sv
// wildcard pattern matcher top level: input stage, match step and result register
//
// The block takes one name character per beat and compares it with a
// wildcard pattern of up to MAX_PATTERN characters held in the cfg_
// registers. '?' matches any single character; '*' skips name characters
// until one equals the pattern character after the star, and a later
// literal mismatch falls back to the last star. A beat with in_is_end set
// produces one beat on the out_ channel carrying out_matched and returns
// the match state to its reset value; a character of zero is dropped.
// A new beat is accepted every cycle unless the input stalls. Each beat is
// captured in an input register and resolved from there by one pass of
// compare logic (one byte comparator per pattern position); the answer for
// an end beat is then registered in the result register. Only an end beat can
// stall the input, and only while the result register is full and stalled.
// The end of the pattern (length, saturation and first nul byte) is
// resolved when the pattern registers are written, so patterns must be
// written while no name is in flight.
module wildcard_pattern_matcher_top
  import wpm_pkg::*;
#(
  parameter int MAX_PATTERN = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CH_W-1:0]       in_ch,
  input  logic                  in_is_end,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_matched,
  // configuration port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int SLOTS = 1 << IDX_W;

  // pattern bank
  logic [MAX_PATTERN*CH_W-1:0] pat_chars;
  logic [SLOTS-1:0]            dead;
  logic [SLOTS-1:0]            is_one;
  logic [SLOTS-1:0]            is_any;
  logic                        exact;

  wpm_cfg #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pat_chars (pat_chars),
    .dead      (dead),
    .is_one    (is_one),
    .is_any    (is_any),
    .exact     (exact)
  );

  // input stage
  logic            s1_valid_r, s1_valid_nxt;
  logic [CH_W-1:0] s1_ch_r, s1_ch_nxt;
  logic            s1_end_r, s1_end_nxt;

  // match state
  match_st_t st_r, st_nxt;

  // result register
  logic out_valid_r, out_valid_nxt;
  logic out_matched_r, out_matched_nxt;

  logic in_acc;
  logic out_free;
  logic s1_go;

  // step decode
  logic [SLOTS-1:0] eq_vec;
  logic             cur_end, cur_hit, cur_one, cur_any;
  pos_t             pos_inc;
  pos_t             la_base, la_pos;
  logic             la_end, la_hit;
  logic             answer;

  // handshake: the result register frees up when empty or being taken
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && s1_end_r && !out_free;
  assign s1_go    = s1_valid_r && !in_stall;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_ch_nxt    = s1_ch_r;
    s1_end_nxt   = s1_end_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
      s1_ch_nxt    = in_ch;
      s1_end_nxt   = in_is_end;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // one comparator per pattern position against the staged character
  always_comb begin
    eq_vec = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      eq_vec[i] = (pat_chars[i*CH_W +: CH_W] == s1_ch_r);
    end
  end

  // current pattern position
  assign cur_end = (st_r.pat_pos >= POS_W'(MAX_PATTERN)) || dead[st_r.pat_pos[IDX_W-1:0]];
  assign cur_hit = !cur_end && eq_vec[st_r.pat_pos[IDX_W-1:0]];
  assign cur_one = !cur_end && is_one[st_r.pat_pos[IDX_W-1:0]];
  assign cur_any = !cur_end && is_any[st_r.pat_pos[IDX_W-1:0]];
  assign pos_inc = st_r.pat_pos + 1'b1;

  // lookahead after a star: the new star here, or the remembered one on fallback
  assign la_base = cur_any ? st_r.pat_pos : st_r.star_pos;
  assign la_pos  = la_base + 1'b1;
  assign la_end  = (la_pos >= POS_W'(MAX_PATTERN)) || dead[la_pos[IDX_W-1:0]];
  assign la_hit  = !la_end && eq_vec[la_pos[IDX_W-1:0]];

  // answer for an end beat
  always_comb begin
    if (st_r.failed) begin
      answer = 1'b0;
    end else if (st_r.overrun) begin
      answer = !exact;
    end else begin
      answer = cur_end;
    end
  end

  always_comb begin
    st_nxt = st_r;
    if (s1_go) begin
      if (s1_end_r) begin
        st_nxt = '0;
      end else if (s1_ch_r == CH_NUL || st_r.failed || st_r.overrun) begin
        st_nxt = st_r;
      end else if (st_r.skipping) begin
        // hunt for the literal after the star
        if (cur_hit) begin
          st_nxt.pat_pos  = pos_inc;
          st_nxt.skipping = 1'b0;
        end
      end else if (cur_end) begin
        st_nxt.overrun = 1'b1;
      end else if (cur_any || (!cur_one && !cur_hit && st_r.star_seen)) begin
        // enter a star, either newly met or by falling back to the last one
        if (cur_any) begin
          st_nxt.star_pos  = st_r.pat_pos;
          st_nxt.star_seen = 1'b1;
        end
        if (la_hit) begin
          st_nxt.pat_pos  = la_pos + 1'b1;
          st_nxt.skipping = 1'b0;
        end else begin
          st_nxt.pat_pos  = la_pos;
          st_nxt.skipping = 1'b1;
        end
      end else if (cur_one || cur_hit) begin
        st_nxt.pat_pos = pos_inc;
      end else begin
        st_nxt.failed = 1'b1;
      end
    end
  end

  // result register
  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_matched_nxt = out_matched_r;
    if (s1_go && s1_end_r) begin
      out_valid_nxt   = 1'b1;
      out_matched_nxt = answer;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_ch_r       <= s1_ch_nxt;
    s1_end_r      <= s1_end_nxt;
    out_matched_r <= out_matched_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;

  // skipping only runs while the match is still live
  a_skip_live: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_r.skipping && (st_r.failed || st_r.overrun)))
    else $error("skipping while failed or overrun");

  // failure and overrun exclude each other
  a_fail_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_r.failed && st_r.overrun))
    else $error("failed and overrun both set");

  // position never runs beyond MAX_PATTERN + 1
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.pat_pos <= POS_W'(MAX_PATTERN + 1))
    else $error("pattern position out of range");

  // input only stalls behind an end beat waiting on the result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_end_r && out_valid_r))
    else $error("input stalled without a pending end beat");

  // a new result only follows a staged end beat
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_end_r))
    else $error("result without an end beat");

endmodule
